### src/ffpa_pkg.sv
// shared types and constants of the first-fit page extent allocator
package ffpa_pkg;

  localparam int PAGE_BITS           = 20;
  localparam int COUNT_BITS          = 21;
  localparam int END_BITS            = 22;
  localparam int MAX_EXTENTS_DEFAULT = 32;

  // first page past the page space
  localparam logic [END_BITS-1:0] SPACE_END = END_BITS'(1) << PAGE_BITS;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOTFREE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [PAGE_BITS-1:0]  page_index;
    logic [COUNT_BITS-1:0] page_count;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PAGE_BITS-1:0] granted_index;
  } out_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  start;
    logic [COUNT_BITS-1:0] length;
  } entry_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_SCAN_RD,
    FS_SCAN_CHK,
    FS_DROP_RD,
    FS_DROP_WR,
    FS_SHIFT_RD,
    FS_SHIFT_WR,
    FS_PUT_HI,
    FS_PUT_LO
  } fsm_t;

endpackage

### src/first_fit_page_extent_allocator.sv
// top level: extent table in one memory, scanned and shifted by a sequencer
//
// The block keeps an ordered table of free page extents in a single memory
// with a registered read. An operation is taken when start is high and busy
// is low, and its one result appears for a single cycle with out_strobe; the
// receiver cannot stall it. A non-trivial operation scans the table entry
// by entry (read, then compare) until the first match; an allocate that
// empties an extent, a reserve that consumes one, every free and every
// splitting reserve that finds room then move the entries behind the match
// one at a time (read, then write) through the same memory port. The scan
// and the move together cover the table once. Trivial requests (a free or
// reserve of zero pages, an unused opcode, a free into a full table) are
// answered without leaving idle. No clearing pass is needed after reset.
module first_fit_page_extent_allocator #(
  parameter int MAX_EXTENTS = ffpa_pkg::MAX_EXTENTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ffpa_pkg::in_t  in_item,
  output logic           out_strobe,
  output ffpa_pkg::out_t out_result
);

  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int PB = ffpa_pkg::PAGE_BITS;
  localparam int CB = ffpa_pkg::COUNT_BITS;
  localparam int EB = ffpa_pkg::END_BITS;

  // extent table
  ffpa_pkg::entry_t mem [MAX_EXTENTS];
  ffpa_pkg::entry_t rd_r;
  logic [IW-1:0]    raddr;
  logic             we;
  logic [IW-1:0]    waddr;
  ffpa_pkg::entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // control and operand registers
  ffpa_pkg::fsm_t   state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [PB-1:0]    idx_r, idx_nxt;
  logic [CB-1:0]    cnt_r, cnt_nxt;
  logic [EB-1:0]    end_r, end_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  ffpa_pkg::entry_t lo_r, lo_nxt;
  ffpa_pkg::entry_t hi_r, hi_nxt;
  logic             split_r, split_nxt;
  logic             out_valid_r, out_valid_nxt;
  ffpa_pkg::out_t   out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffpa_pkg::FS_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r    <= op_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    end_r   <= end_nxt;
    k_r     <= k_nxt;
    pos_r   <= pos_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    split_r <= split_nxt;
    out_r   <= out_nxt;
  end

  // derived values
  logic [CW-1:0] k_inc, k_dec, pos_inc;
  logic [CW:0]   k_inc2;
  logic [EB-1:0] in_sum, e_end, back_w;
  logic [PB-1:0] front_w;
  logic [CB-1:0] len_left;
  logic [PB-1:0] start_adv;
  logic          table_full;

  assign k_inc      = k_r + CW'(1);
  assign k_dec      = k_r - CW'(1);
  assign k_inc2     = {1'b0, k_r} + (CW+1)'(2);
  assign pos_inc    = pos_r + CW'(1);
  assign in_sum     = {2'b0, in_item.page_index} + {1'b0, in_item.page_count};
  assign e_end      = {2'b0, rd_r.start} + {1'b0, rd_r.length};
  assign back_w     = e_end - end_r;
  assign front_w    = idx_r - rd_r.start;
  assign len_left   = rd_r.length - cnt_r;
  assign start_adv  = rd_r.start + cnt_r[PB-1:0];
  assign table_full = (used_r == CW'(MAX_EXTENTS));

  assign busy       = (state_r != ffpa_pkg::FS_IDLE);
  assign out_strobe = out_valid_r;
  assign out_result = out_r;

  // sequencer
  always_comb begin
    logic hit;
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    used_nxt      = used_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    split_nxt     = split_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    raddr         = k_r[IW-1:0];
    we            = 1'b0;
    waddr         = k_r[IW-1:0];
    wdata         = rd_r;
    hit           = 1'b0;

    case (state_r)
      ffpa_pkg::FS_IDLE: begin
        if (start) begin
          op_nxt    = in_item.op;
          idx_nxt   = in_item.page_index;
          cnt_nxt   = in_item.page_count;
          end_nxt   = in_sum;
          k_nxt     = '0;
          out_nxt   = '{status: ffpa_pkg::ST_OK, granted_index: '0};
          case (in_item.op)
            ffpa_pkg::OP_ALLOC: begin
              state_nxt = ffpa_pkg::FS_SCAN_RD;
            end
            ffpa_pkg::OP_FREE: begin
              // clip the extent at the end of the page space
              if (in_sum > ffpa_pkg::SPACE_END) begin
                cnt_nxt = CB'(ffpa_pkg::SPACE_END - {2'b0, in_item.page_index});
                end_nxt = ffpa_pkg::SPACE_END;
              end
              if (in_item.page_count == '0) begin
                out_valid_nxt = 1'b1;
              end else if (table_full) begin
                out_nxt.status = ffpa_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = ffpa_pkg::FS_SCAN_RD;
              end
            end
            ffpa_pkg::OP_RESERVE: begin
              if (in_item.page_count == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ffpa_pkg::FS_SCAN_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // fetch the next entry, or handle the end of the table
      ffpa_pkg::FS_SCAN_RD: begin
        raddr = k_r[IW-1:0];
        if (k_r == used_r) begin
          case (op_r)
            ffpa_pkg::OP_FREE: begin
              pos_nxt   = used_r;
              lo_nxt    = '{start: idx_r, length: cnt_r};
              split_nxt = 1'b0;
              k_nxt     = used_r;
              state_nxt = ffpa_pkg::FS_SHIFT_RD;
            end
            ffpa_pkg::OP_ALLOC: begin
              out_nxt.status = ffpa_pkg::ST_NOFIT;
              out_valid_nxt  = 1'b1;
              state_nxt      = ffpa_pkg::FS_IDLE;
            end
            default: begin
              out_nxt.status = ffpa_pkg::ST_NOTFREE;
              out_valid_nxt  = 1'b1;
              state_nxt      = ffpa_pkg::FS_IDLE;
            end
          endcase
        end else begin
          state_nxt = ffpa_pkg::FS_SCAN_CHK;
        end
      end

      // compare the fetched entry and act on the first match
      ffpa_pkg::FS_SCAN_CHK: begin
        case (op_r)
          ffpa_pkg::OP_ALLOC: hit = (rd_r.length >= cnt_r);
          ffpa_pkg::OP_FREE:  hit = (end_r <= {2'b0, rd_r.start});
          default:            hit = (rd_r.start <= idx_r) && (end_r <= e_end);
        endcase
        pos_nxt = k_r;
        waddr   = k_r[IW-1:0];
        if (!hit) begin
          k_nxt     = k_inc;
          state_nxt = ffpa_pkg::FS_SCAN_RD;
        end else begin
          case (op_r)
            ffpa_pkg::OP_ALLOC: begin
              out_nxt.granted_index = rd_r.start;
              if (len_left == '0) begin
                state_nxt = ffpa_pkg::FS_DROP_RD;
              end else begin
                we            = 1'b1;
                wdata         = '{start: start_adv, length: len_left};
                out_valid_nxt = 1'b1;
                state_nxt     = ffpa_pkg::FS_IDLE;
              end
            end
            ffpa_pkg::OP_FREE: begin
              lo_nxt    = '{start: idx_r, length: cnt_r};
              split_nxt = 1'b0;
              k_nxt     = used_r;
              state_nxt = ffpa_pkg::FS_SHIFT_RD;
            end
            default: begin
              // reserve: keep front part, back part, both or nothing
              if (front_w != '0 && back_w != '0) begin
                if (table_full) begin
                  out_nxt.status = ffpa_pkg::ST_FULL;
                  out_valid_nxt  = 1'b1;
                  state_nxt      = ffpa_pkg::FS_IDLE;
                end else begin
                  lo_nxt    = '{start: rd_r.start, length: CB'(front_w)};
                  hi_nxt    = '{start: end_r[PB-1:0], length: back_w[CB-1:0]};
                  split_nxt = 1'b1;
                  k_nxt     = used_r;
                  state_nxt = ffpa_pkg::FS_SHIFT_RD;
                end
              end else if (front_w != '0) begin
                we            = 1'b1;
                wdata         = '{start: rd_r.start, length: CB'(front_w)};
                out_valid_nxt = 1'b1;
                state_nxt     = ffpa_pkg::FS_IDLE;
              end else if (back_w != '0) begin
                we            = 1'b1;
                wdata         = '{start: end_r[PB-1:0], length: back_w[CB-1:0]};
                out_valid_nxt = 1'b1;
                state_nxt     = ffpa_pkg::FS_IDLE;
              end else begin
                state_nxt = ffpa_pkg::FS_DROP_RD;
              end
            end
          endcase
        end
      end

      // close the gap left by a removed entry
      ffpa_pkg::FS_DROP_RD: begin
        raddr = k_inc[IW-1:0];
        if (k_inc2 <= {1'b0, used_r}) begin
          state_nxt = ffpa_pkg::FS_DROP_WR;
        end else begin
          used_nxt      = used_r - CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = ffpa_pkg::FS_IDLE;
        end
      end

      ffpa_pkg::FS_DROP_WR: begin
        we        = 1'b1;
        waddr     = k_r[IW-1:0];
        wdata     = rd_r;
        k_nxt     = k_inc;
        state_nxt = ffpa_pkg::FS_DROP_RD;
      end

      // open a gap at the insert position, moving from the tail down
      ffpa_pkg::FS_SHIFT_RD: begin
        raddr = k_dec[IW-1:0];
        if (k_r > pos_r) begin
          state_nxt = ffpa_pkg::FS_SHIFT_WR;
        end else if (split_r) begin
          state_nxt = ffpa_pkg::FS_PUT_HI;
        end else begin
          state_nxt = ffpa_pkg::FS_PUT_LO;
        end
      end

      ffpa_pkg::FS_SHIFT_WR: begin
        we        = 1'b1;
        waddr     = k_r[IW-1:0];
        wdata     = rd_r;
        k_nxt     = k_dec;
        state_nxt = ffpa_pkg::FS_SHIFT_RD;
      end

      // back part of a split reserve
      ffpa_pkg::FS_PUT_HI: begin
        we        = 1'b1;
        waddr     = pos_inc[IW-1:0];
        wdata     = hi_r;
        state_nxt = ffpa_pkg::FS_PUT_LO;
      end

      // new entry at the insert position
      ffpa_pkg::FS_PUT_LO: begin
        we            = 1'b1;
        waddr         = pos_r[IW-1:0];
        wdata         = lo_r;
        used_nxt      = used_r + CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = ffpa_pkg::FS_IDLE;
      end

      default: begin
        state_nxt = ffpa_pkg::FS_IDLE;
      end
    endcase
  end

endmodule
